// ===== hdl/lusf_pkg.sv =====
// Package for the largest uniform square finder.
// Holds the field widths, reset values and parameter defaults used by the interfaces, the top level and the testbench.
// Depends on nothing.
`default_nettype none

package lusf_pkg;

  // Widths of the fields carried by the channels and the configuration port.
  localparam int unsigned CELL_W       = 16;
  localparam int unsigned AREA_W       = 21;
  localparam int unsigned SIDE_FIELD_W = 11;
  localparam int unsigned CFG_W        = 11;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_SIDE_DEF   = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Reset value of the grid side register.
  localparam logic [CFG_W-1:0] GRID_SIDE_RESET = CFG_W'(1024);

endpackage : lusf_pkg

`default_nettype wire

// ===== hdl/lusf_cell_if.sv =====
// Input channel of the square finder: valid/ready handshake carrying one grid cell.
// Depends on lusf_pkg for the cell width.
`default_nettype none

interface lusf_cell_if;
  import lusf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);

endinterface : lusf_cell_if

`default_nettype wire

// ===== hdl/lusf_result_if.sv =====
// Output channel of the square finder: valid/ready handshake carrying one result.
// Depends on lusf_pkg for the area and side widths.
`default_nettype none

interface lusf_result_if;
  import lusf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [AREA_W-1:0]       square_area;
  logic [SIDE_FIELD_W-1:0] square_side;

  modport source (output valid, output square_area, output square_side, input ready);
  modport sink   (input valid, input square_area, input square_side, output ready);

endinterface : lusf_result_if

`default_nettype wire

// ===== hdl/lusf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; used for the line buffer of the square finder.
`default_nettype none

module lusf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : lusf_ram

`default_nettype wire

// ===== hdl/largest_uniform_square_finder_top.sv =====
// Largest uniform square finder: top level.
// Depends on lusf_pkg, lusf_cell_if, lusf_result_if and lusf_ram.
//
// Usage:
//   Cells of a square grid arrive on cell_i, one item per handshake, in raster
//   order. The grid side is set through cfg_we_i/cfg_wdata_i while the block is
//   idle; a write restarts the grid. A side of zero counts as 1 and a side above
//   MAX_SIDE counts as MAX_SIDE.
//   When the last cell of a grid has been taken, one item appears on result_o
//   with the side and the area of the largest square whose cells all share one
//   value (at least 1x1). The block then starts on a fresh grid.
// Timing:
//   One cell is taken every cycle unless a last cell waits for a pending result. A
//   cell sits in the input register while the line buffer RAM returns its upper
//   neighbour; the result item is registered once the last cell leaves that register.
//   The line buffer RAM has one read and one write port, which together set the
//   rate of one cell per cycle.
// Reset and stalls:
//   Reset clears the counters and the neighbour values, sets the neighbour sides and
//   the best side to 1 and the grid side to 1024. The line buffer needs no clearing. While a
//   result waits, cells keep flowing; only a further last cell waits for it.
`default_nettype none

module largest_uniform_square_finder_top #(
  parameter int unsigned MAX_SIDE   = lusf_pkg::MAX_SIDE_DEF,
  parameter int unsigned VALUE_BITS = lusf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lusf_pkg::CFG_W-1:0] cfg_wdata_i,
  lusf_cell_if.sink                       cell_i,
  lusf_result_if.source                   result_o
);
  import lusf_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned LB_W   = VALUE_BITS + SIDE_W;

  // Configuration register.
  logic [CFG_W-1:0] grid_side_q;

  // Input-side position counters.
  logic [IDX_W-1:0] col_q, col_d;
  logic [IDX_W-1:0] row_q, row_d;

  // Input register (stage 1).
  logic                  s1_valid_q;
  logic [VALUE_BITS-1:0] s1_cell_q;
  logic [IDX_W-1:0]      s1_col_q;
  logic                  s1_first_col_q;
  logic                  s1_first_row_q;
  logic                  s1_grid_last_q;

  // Neighbour and best-side registers.
  logic [VALUE_BITS-1:0] left_val_q;
  logic [SIDE_W-1:0]     left_side_q;
  logic [VALUE_BITS-1:0] diag_val_q;
  logic [SIDE_W-1:0]     diag_side_q;
  logic [SIDE_W-1:0]     best_q;

  // Result register.
  logic                    out_valid_q;
  logic [AREA_W-1:0]       out_area_q;
  logic [SIDE_FIELD_W-1:0] out_side_q;

  logic                  in_accept;
  logic                  s1_advance;
  logic [VALUE_BITS-1:0] cell_v;
  logic [31:0]           grid_ext;
  logic [SIDE_W-1:0]     eff_side;
  logic [IDX_W-1:0]      last_idx;
  logic                  col_last;
  logic                  row_last;

  logic [IDX_W-1:0]      lb_raddr;
  logic [LB_W-1:0]       lb_rdata;
  logic [VALUE_BITS-1:0] up_val;
  logic [SIDE_W-1:0]     up_side;
  logic                  match;
  logic [SIDE_W-1:0]     min_ul;
  logic [SIDE_W-1:0]     min3;
  logic [SIDE_W-1:0]     side_d;
  logic [SIDE_W-1:0]     best_d;
  logic [2*SIDE_W-1:0]   area_full;

  // Only the low VALUE_BITS bits of a cell take part in the comparisons.
  if (VALUE_BITS <= CELL_W) begin : g_cell_narrow
    assign cell_v = cell_i.cell_value[VALUE_BITS-1:0];
  end else begin : g_cell_wide
    assign cell_v = {{(VALUE_BITS - CELL_W){1'b0}}, cell_i.cell_value};
  end

  // Effective grid side, with zero raised to 1 and large values saturated.
  assign grid_ext = 32'(grid_side_q);
  always_comb begin
    if (grid_side_q == '0) begin
      eff_side = SIDE_W'(1);
    end else if (grid_ext > MAX_SIDE) begin
      eff_side = SIDE_W'(MAX_SIDE);
    end else begin
      eff_side = SIDE_W'(grid_side_q);
    end
  end
  assign last_idx = IDX_W'(eff_side - SIDE_W'(1));
  assign col_last = (col_q == last_idx);
  assign row_last = (row_q == last_idx);

  // Handshakes: stage 1 moves on unless its last cell would overwrite a waiting result.
  assign s1_advance   = s1_valid_q && (!s1_grid_last_q || !out_valid_q || result_o.ready);
  assign cell_i.ready = !s1_valid_q || s1_advance;
  assign in_accept    = cell_i.valid && cell_i.ready;

  // Position counters in raster order.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RESET;
      col_q       <= '0;
      row_q       <= '0;
    end else if (cfg_we_i) begin
      grid_side_q <= cfg_wdata_i;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cell_q      <= cell_v;
      s1_col_q       <= col_q;
      s1_first_col_q <= (col_q == '0);
      s1_first_row_q <= (row_q == '0);
      s1_grid_last_q <= col_last && row_last;
    end
  end

  // Line buffer: the read for a cell is issued as it is accepted and held while it waits.
  assign lb_raddr = in_accept ? col_q : s1_col_q;

  lusf_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_SIDE)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_advance),
    .waddr_i (s1_col_q),
    .wdata_i ({s1_cell_q, side_d}),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  // The upper neighbour reads as zero on the top row.
  assign up_val  = s1_first_row_q ? '0 : lb_rdata[LB_W-1:SIDE_W];
  assign up_side = s1_first_row_q ? '0 : lb_rdata[SIDE_W-1:0];

  // Side of the current cell and the running best.
  assign match = !s1_first_col_q && !s1_first_row_q &&
                 (up_val == s1_cell_q) && (left_val_q == s1_cell_q) &&
                 (diag_val_q == s1_cell_q);
  assign min_ul = (left_side_q < up_side) ? left_side_q : up_side;
  assign min3   = (diag_side_q < min_ul) ? diag_side_q : min_ul;
  assign side_d = match ? min3 + SIDE_W'(1) : SIDE_W'(1);
  assign best_d = (side_d > best_q) ? side_d : best_q;

  // Neighbour registers; a finished grid or a configuration write restarts them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_val_q  <= '0;
      left_side_q <= SIDE_W'(1);
      diag_val_q  <= '0;
      diag_side_q <= SIDE_W'(1);
      best_q      <= SIDE_W'(1);
    end else if (cfg_we_i || (s1_advance && s1_grid_last_q)) begin
      left_val_q  <= '0;
      left_side_q <= SIDE_W'(1);
      diag_val_q  <= '0;
      diag_side_q <= SIDE_W'(1);
      best_q      <= SIDE_W'(1);
    end else if (s1_advance) begin
      left_val_q  <= s1_cell_q;
      left_side_q <= side_d;
      diag_val_q  <= up_val;
      diag_side_q <= up_side;
      best_q      <= best_d;
    end
  end

  // Result register.
  assign area_full = {{SIDE_W{1'b0}}, best_d} * {{SIDE_W{1'b0}}, best_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_grid_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_grid_last_q) begin
      out_area_q <= AREA_W'(area_full);
      out_side_q <= SIDE_FIELD_W'(best_d);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.square_area = out_area_q;
  assign result_o.square_side = out_side_q;

endmodule : largest_uniform_square_finder_top

`default_nettype wire

// ===== verif/largest_uniform_square_finder_top_test.sv =====
// Testbench for the largest uniform square finder top level.
// Holds a self-checking predictor of the square search, a handshake driver and monitor.
// Depends on lusf_pkg, lusf_cell_if, lusf_result_if and the top level under hdl.
`timescale 1ns / 1ps

module largest_uniform_square_finder_top_test;
  import lusf_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned CELL_TARGET  = 520;

  typedef enum int unsigned {
    FILL_PATCHY,
    FILL_TWO_TONE,
    FILL_NOISE,
    FILL_FLAT
  } fill_e;

  typedef struct packed {
    logic [AREA_W-1:0]       area;
    logic [SIDE_FIELD_W-1:0] side;
  } square_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  lusf_cell_if   cell_ch ();
  lusf_result_if result_ch ();

  largest_uniform_square_finder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_i     (cell_ch),
    .result_o   (result_ch)
  );

  // Cells waiting to be offered and squares waiting to come out.
  logic [CELL_W-1:0] cell_queue[$];
  square_t           pending_squares[$];

  // Own copy of the grid state.
  logic [CFG_W-1:0]        grid_side_reg;
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  logic [CELL_W-1:0]       line_values[MAX_SIDE_DEF];
  int unsigned             line_sides[MAX_SIDE_DEF];
  logic [CELL_W-1:0]       left_val;
  int unsigned             left_s;
  logic [CELL_W-1:0]       diag_val;
  int unsigned             diag_s;
  int unsigned             best_s;

  // Run bookkeeping.
  int unsigned error_count;
  int unsigned cells_fed;
  int unsigned squares_checked;
  int unsigned largest_seen;
  int unsigned side_writes;
  int unsigned hold_requests;
  int unsigned holds_served;
  bit          src_burst;
  bit          snk_burst;

  // Driver and monitor counters.
  int unsigned src_gap;
  int unsigned snk_stall;
  int unsigned hold_left;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #3_000_000;
    $display("largest_uniform_square_finder_top_test NOT OK");
    $finish;
  end

  // Grid restart: counters, neighbours and best side return to their reset values.
  task automatic restart_grid();
    col_cnt  = 0;
    row_cnt  = 0;
    left_val = '0;
    left_s   = 1;
    diag_val = '0;
    diag_s   = 1;
    best_s   = 1;
  endtask

  function automatic int unsigned grid_cells_per_row();
    if (grid_side_reg == '0) return 1;
    if (grid_side_reg > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return grid_side_reg;
  endfunction

  // Works out the square side of one accepted cell and queues the answer on the last cell.
  task automatic track_cell(input logic [CELL_W-1:0] value);
    int unsigned       n;
    int unsigned       x;
    int unsigned       y;
    int unsigned       up_s;
    int unsigned       s;
    int unsigned       m;
    logic [CELL_W-1:0] up_v;
    square_t           sq;
    n    = grid_cells_per_row();
    x    = col_cnt;
    y    = row_cnt;
    up_v = '0;
    up_s = 0;
    s    = 1;
    if (y > 0) begin
      up_v = line_values[x];
      up_s = line_sides[x];
    end
    if (x > 0 && y > 0 && up_v == value && left_val == value && diag_val == value) begin
      m = up_s;
      if (left_s < m) m = left_s;
      if (diag_s < m) m = diag_s;
      s = m + 1;
    end
    if (s > best_s) best_s = s;
    // The old upper entry becomes the next cell's diagonal.
    diag_val       = up_v;
    diag_s         = up_s;
    line_values[x] = value;
    line_sides[x]  = s;
    left_val       = value;
    left_s         = s;
    if (x + 1 >= n) begin
      if (y + 1 >= n) begin
        sq.area = AREA_W'(best_s * best_s);
        sq.side = SIDE_FIELD_W'(best_s);
        pending_squares.push_back(sq);
        restart_grid();
      end else begin
        col_cnt = 0;
        row_cnt = y + 1;
      end
    end else begin
      col_cnt = x + 1;
    end
  endtask

  // Cell driver: offers queued cells, with a random gap between them outside burst mode.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) track_cell(cell_ch.cell_value);
      if (!cell_ch.valid || cell_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          cell_ch.valid <= 1'b0;
        end else if (cell_queue.size() != 0) begin
          cell_ch.valid      <= 1'b1;
          cell_ch.cell_value <= cell_queue.pop_front();
          src_gap = src_burst ? 0 : $urandom_range(0, 7);
        end else begin
          cell_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result item and stalls the output at random or for a long hold on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      snk_stall = 0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_squares.size() == 0) begin
          $display("%0t: unexpected result, area %0d side %0d", $time,
                   result_ch.square_area, result_ch.square_side);
          error_count++;
        end else begin
          if (result_ch.square_area !== pending_squares[0].area) begin
            $display("%0t: square_area expected %0d actual %0d", $time,
                     pending_squares[0].area, result_ch.square_area);
            error_count++;
          end
          if (result_ch.square_side !== pending_squares[0].side) begin
            $display("%0t: square_side expected %0d actual %0d", $time,
                     pending_squares[0].side, result_ch.square_side);
            error_count++;
          end
          if (pending_squares[0].side > largest_seen) largest_seen = pending_squares[0].side;
          void'(pending_squares.pop_front());
          squares_checked++;
        end
        snk_stall = snk_burst ? 0 : $urandom_range(0, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_cell(input logic [CELL_W-1:0] value);
    cell_queue.push_back(value);
    cells_fed++;
  endtask

  // Writes the grid side while the block is idle.
  task automatic write_side(input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    grid_side_reg = value;
    restart_grid();
    side_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every cell is taken and every square is out, or a limit runs out, then lets the pipeline settle.
  task automatic wait_idle();
    int unsigned spent;
    spent = 0;
    @(negedge clk_i);
    while ((cell_queue.size() != 0 || cell_ch.valid || pending_squares.size() != 0)
           && spent < IDLE_LIMIT) begin
      @(negedge clk_i);
      spent++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [CELL_W-1:0] draw_cell(input fill_e fill,
                                                  input logic [CELL_W-1:0] base);
    case (fill)
      FILL_PATCHY: begin
        if ($urandom_range(0, 6) == 0)
          return base ^ (CELL_W'(1) << $urandom_range(0, CELL_W - 1));
        return base;
      end
      FILL_TWO_TONE: return ($urandom_range(0, 1) == 0) ? base : ~base;
      FILL_NOISE:    return CELL_W'($urandom);
      default:       return base;
    endcase
  endfunction

  // Queues a number of cells drawn in one style around one base value.
  task automatic feed_cells(input int unsigned count, input fill_e fill);
    logic [CELL_W-1:0] base;
    int unsigned       odd_at;
    base   = CELL_W'($urandom);
    odd_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, count - 1) : count;
    for (int unsigned i = 0; i < count; i++) begin
      if (fill == FILL_FLAT && i == odd_at) push_cell(~base);
      else push_cell(draw_cell(fill, base));
    end
  endtask

  // Stimulus: directed cases, the pressure phases, then random grids.
  initial begin
    int unsigned side;
    int unsigned grids;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    cell_ch.valid      = 1'b0;
    cell_ch.cell_value = '0;
    result_ch.ready    = 1'b0;
    error_count        = 0;
    cells_fed          = 0;
    squares_checked    = 0;
    largest_seen       = 0;
    side_writes        = 0;
    hold_requests      = 0;
    holds_served       = 0;
    src_burst          = 1'b0;
    snk_burst          = 1'b0;
    grid_side_reg      = GRID_SIDE_RESET;
    restart_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Start of a full-size grid at the reset side, cut short by a write.
    push_cell(16'h0000);
    push_cell(16'hFFFF);
    push_cell(16'hAAAA);
    push_cell(16'h5555);
    push_cell(16'hFFFF);
    push_cell(16'h0000);
    push_cell(16'h8001);
    push_cell(16'h7FFE);
    wait_idle();

    // A side above the maximum saturates; again left unfinished.
    write_side(CFG_W'(2047));
    push_cell(16'hFFFF);
    push_cell(16'hFFFF);
    push_cell(16'h0000);
    wait_idle();

    // Side zero counts as one, so every cell is a whole grid.
    write_side('0);
    push_cell(16'h0000);
    push_cell(16'hFFFF);
    wait_idle();
    write_side(CFG_W'(1));
    push_cell(16'h1234);
    push_cell(16'hFFFF);
    wait_idle();

    // A uniform 3x3 grid gives its full side.
    write_side(CFG_W'(3));
    for (int unsigned i = 0; i < 9; i++) push_cell(16'hFFFF);
    wait_idle();

    // The output holds off while one-cell grids keep coming, so the input stalls.
    src_burst = 1'b1;
    write_side(CFG_W'(1));
    hold_requests++;
    for (int unsigned i = 0; i < 24; i++) push_cell(CELL_W'($urandom));
    wait_idle();
    write_side(CFG_W'(2));
    hold_requests++;
    for (int unsigned i = 0; i < 6; i++) feed_cells(4, fill_e'($urandom_range(0, 3)));
    wait_idle();
    src_burst = 1'b0;

    // Random grids, mostly small and complete, some left unfinished before the next write.
    while (cells_fed < CELL_TARGET) begin
      side      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      src_burst = ($urandom_range(0, 3) == 0);
      snk_burst = ($urandom_range(0, 3) == 0);
      write_side(CFG_W'(side));
      grids = $urandom_range(1, 3);
      for (int unsigned g = 0; g < grids; g++)
        feed_cells(side * side, fill_e'($urandom_range(0, 3)));
      if (side > 1 && $urandom_range(0, 5) == 0)
        feed_cells($urandom_range(1, side * side - 1), fill_e'($urandom_range(0, 3)));
      wait_idle();
    end

    wait_idle();
    if (pending_squares.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_squares.size());
      error_count++;
    end
    $display("Fed %0d cells over %0d grid side writes; checked %0d squares, largest side %0d.",
             cells_fed, side_writes, squares_checked, largest_seen);
    if (error_count == 0) begin
      $display("largest_uniform_square_finder_top_test OK");
    end else begin
      $display("largest_uniform_square_finder_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lusf_pkg.sv
hdl/lusf_cell_if.sv
hdl/lusf_result_if.sv
hdl/lusf_ram.sv
hdl/largest_uniform_square_finder_top.sv
verif/largest_uniform_square_finder_top_test.sv
